[rtl/stb_pkg.sv]
// Shared types and constants of the software timer bank.
package stb_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned IndexW = 4;
  localparam int unsigned UseW   = 5;
  localparam int unsigned FuncW  = 2;
  // Largest number of timers a tick may visit: the index field is 4 bits.
  localparam int unsigned MaxScan = 16;

  typedef enum logic [FuncW-1:0] {
    FN_ARM    = 2'd0,
    FN_DISARM = 2'd1,
    FN_TICK   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_EX,
    ST_FLUSH
  } state_e;

  // Result of the shared decrement unit for one timer.
  typedef struct packed {
    logic              expire;
    logic [CountW-1:0] wr_count;
  } dec_res_t;

endpackage

[rtl/software_timer_bank.sv]
// Top level of the software timer bank: sequencer, storage and output register.
//
//  channel  | direction | transfer fields (tdata / tuser / tlast)
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | tdata: timer_index, timeout, interval; tuser: func
//  m_axis   | out       | tdata: expired_timer; tlast: last
//  cfg      | in        | data: timers_in_use, always ready
//
//  Arm and disarm are written in the cycle they are taken. A tick walks the N
//  timers in use (at most 16): each timer needs a RAM read step and a decrement
//  and write-back step through the shared decrement unit, plus a closing step.
//  Reset clears the timer bank at once through per-entry valid bits; an entry
//  never armed reads as zero. A stalled output holds the scan on the next
//  expiry only; a result may wait in the output register while a new item
//  is taken.
module software_timer_bank #(
  parameter int NUM_TIMERS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave side
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [3:0] timer_index, [35:4] timeout, [67:36] interval, [71:68] zero
  input  logic [71:0]  s_axis_tdata,
  // [1:0] func
  input  logic [1:0]   s_axis_tuser,
  // master side
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [3:0] expired_timer, [7:4] zero
  output logic [7:0]   m_axis_tdata,
  output logic         m_axis_tlast,
  // configuration
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [4:0]   cfg_data_i
);
  import stb_pkg::*;

  localparam int AddrW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int MaxN  = (NUM_TIMERS < MaxScan) ? NUM_TIMERS : MaxScan;
  localparam logic [UseW-1:0] MaxNW = UseW'(MaxN);

  // Unpack the input transfer.
  logic [IndexW-1:0] in_index;
  logic [CountW-1:0] in_timeout;
  logic [CountW-1:0] in_interval;
  func_e             in_func;

  assign in_index    = s_axis_tdata[3:0];
  assign in_timeout  = s_axis_tdata[35:4];
  assign in_interval = s_axis_tdata[67:36];
  assign in_func     = func_e'(s_axis_tuser);

  // Configuration register.
  logic [UseW-1:0] use_q;
  logic [UseW-1:0] n_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q <= '0;
    end else if (cfg_valid_i) begin
      use_q <= cfg_data_i;
    end
  end

  // Saturate to the bank size and to the index range.
  assign n_eff = (use_q > MaxNW) ? MaxNW : use_q;

  // Sequencer state.
  state_e            state_q, state_d;
  logic [UseW-1:0]   scan_q, scan_d;
  logic              pend_vld_q, pend_vld_d;
  logic [IndexW-1:0] pend_idx_q, pend_idx_d;
  logic              out_vld_q, out_vld_d;
  logic [IndexW-1:0] out_idx_q, out_idx_d;
  logic              out_last_q, out_last_d;
  logic [NUM_TIMERS-1:0] valid_q, valid_d;

  logic              in_acc;
  logic              slot_free;
  logic              addr_ok;
  logic              scan_end;
  logic              ex_go;

  // RAM ports.
  logic              cnt_we, rl_we, rd_en;
  logic [AddrW-1:0]  waddr, raddr;
  logic [CountW-1:0] cnt_wdata;
  logic [CountW-1:0] cnt_rdata, rl_rdata;
  logic [CountW-1:0] cur_count, cur_reload;
  dec_res_t          dec_res;
  logic              entry_vld;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_vld_q || m_axis_tready;
  assign addr_ok   = {1'b0, in_index} < n_eff;
  assign scan_end  = (scan_q + UseW'(1)) == n_eff;
  assign raddr     = AddrW'(scan_q);
  assign entry_vld = valid_q[raddr];

  // An entry never armed since reset reads as zero.
  assign cur_count  = entry_vld ? cnt_rdata : '0;
  assign cur_reload = entry_vld ? rl_rdata  : '0;

  stb_dec_unit u_dec (
    .count_i  (cur_count),
    .reload_i (cur_reload),
    .res_o    (dec_res)
  );

  // Hold the scan when a second expiry needs the busy output register.
  assign ex_go = !(dec_res.expire && pend_vld_q && !slot_free);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_func == FN_TICK) begin
          state_d = (n_eff == '0) ? ST_FLUSH : ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_EX;
      end
      ST_EX: begin
        if (ex_go) begin
          state_d = scan_end ? ST_FLUSH : ST_RD;
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q || slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    scan_d     = scan_q;
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_idx_d  = out_idx_q;
    out_last_d = out_last_q;
    valid_d    = valid_q;
    cnt_we     = 1'b0;
    rl_we      = 1'b0;
    rd_en      = 1'b0;
    waddr      = raddr;
    cnt_wdata  = dec_res.wr_count;
    unique case (state_q)
      ST_IDLE: begin
        scan_d = '0;
        waddr  = AddrW'(in_index);
        if (in_acc && addr_ok) begin
          unique case (in_func)
            FN_ARM: begin
              cnt_we         = 1'b1;
              rl_we          = 1'b1;
              cnt_wdata      = in_timeout;
              valid_d[waddr] = 1'b1;
            end
            FN_DISARM: begin
              // Leave the reload value in place; only stop the count.
              cnt_we    = 1'b1;
              cnt_wdata = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        rd_en = 1'b1;
      end
      ST_EX: begin
        if (ex_go) begin
          cnt_we = 1'b1;
          scan_d = scan_q + UseW'(1);
          if (dec_res.expire) begin
            if (pend_vld_q) begin
              out_vld_d  = 1'b1;
              out_idx_d  = pend_idx_q;
              out_last_d = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_idx_d = scan_q[IndexW-1:0];
          end
        end
      end
      ST_FLUSH: begin
        // The held expiry is the final one of this tick.
        if (pend_vld_q && slot_free) begin
          out_vld_d  = 1'b1;
          out_idx_d  = pend_idx_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      valid_q    <= '0;
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  stb_ram #(
    .Width (CountW),
    .Depth (NUM_TIMERS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (waddr),
    .wdata_i (cnt_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (cnt_rdata)
  );

  stb_ram #(
    .Width (CountW),
    .Depth (NUM_TIMERS)
  ) u_reload_ram (
    .clk_i   (clk_i),
    .we_i    (rl_we),
    .waddr_i (waddr),
    .wdata_i (in_interval),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rl_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_idx_q};
  assign m_axis_tlast  = out_last_q;

endmodule

[rtl/stb_ram.sv]
// Generic single write port RAM with a registered read port.
module stb_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/stb_dec_unit.sv]
// Shared decrement and expiry check applied to one timer per scan step.
module stb_dec_unit (
  input  logic [stb_pkg::CountW-1:0] count_i,
  input  logic [stb_pkg::CountW-1:0] reload_i,
  output stb_pkg::dec_res_t          res_o
);
  import stb_pkg::*;

  logic [CountW-1:0] dec;

  assign dec = count_i - CountW'(1);

  always_comb begin
    res_o = '0;
    if (count_i == '0) begin
      // disarmed: keep zero
      res_o.wr_count = '0;
    end else if (dec == '0) begin
      res_o.expire   = 1'b1;
      res_o.wr_count = reload_i;
    end else begin
      res_o.wr_count = dec;
    end
  end

endmodule

[tb/sv/tb_software_timer_bank.sv]
// Testbench of the software timer bank: stream driver, result monitor, timer predictor.
`timescale 1ns / 1ps

module tb_software_timer_bank;
  import stb_pkg::*;

  localparam int unsigned NumTimers = 16;
  // Operation code that the block leaves unused; it must be ignored.
  localparam logic [FuncW-1:0] FnUnused = 2'd3;
  // Idle time after settling for a full tick over 16 timers to finish, with margin on top.
  localparam int unsigned DrainCycles = 48;
  // Long receiver hold-off, started once when at least this many results have
  // arrived and enough requests are still waiting to keep the sender busy.
  localparam int unsigned PressureAt = 24;
  localparam int unsigned PressureBacklog = 10;
  localparam int unsigned PressureCycles = 400;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned WatchdogLimit = 4000;

  // One request on the slave side, packed as the block expects it.
  typedef struct packed {
    logic [CountW-1:0] interval;
    logic [CountW-1:0] timeout;
    logic [IndexW-1:0] timer_index;
    logic [FuncW-1:0]  func;
  } timer_req_t;

  // One expiry report on the master side.
  typedef struct packed {
    logic [IndexW-1:0] timer;
    logic              last;
  } expiry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [3:0] timer_index, [35:4] timeout, [67:36] interval, [71:68] zero
  logic [71:0] s_axis_tdata = '0;
  // [1:0] func
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [3:0] expired_timer, [7:4] zero
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;

  // Requests waiting for the driver, and expiries waiting for the monitor.
  timer_req_t  req_q[$];
  expiry_t     expiry_q[$];

  // Predicted timer bank and its setting.
  logic [CountW-1:0] remaining_cnt [NumTimers];
  logic [CountW-1:0] reload_cnt    [NumTimers];
  logic [UseW-1:0]   in_use_cfg = '0;

  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned ticks_seen = 0;
  int unsigned results_seen = 0;
  int unsigned settings_written = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  bit          pressure_done = 1'b0;

  software_timer_bank #(
    .NUM_TIMERS(NumTimers)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Clear the predicted bank to match the state after reset.
  initial begin
    for (int i = 0; i < NumTimers; i++) begin
      remaining_cnt[i] = '0;
      reload_cnt[i] = '0;
    end
  end

  // Number of timers a tick walks: saturate the setting to the bank size and
  // to the 16 timers that the 4-bit index can name.
  function automatic int unsigned scan_count();
    int unsigned n;
    n = 32'(in_use_cfg);
    if (n > NumTimers) n = NumTimers;
    if (n > MaxScan) n = MaxScan;
    return n;
  endfunction

  // Apply one accepted request to the predicted bank and queue the expiries
  // that it causes, in index order, with last on the final one.
  function automatic void advance_timers(timer_req_t req);
    int unsigned n;
    int unsigned hits[$];
    expiry_t     exp_item;
    n = scan_count();
    case (req.func)
      FN_ARM: begin
        if (req.timer_index < n) begin
          remaining_cnt[req.timer_index] = req.timeout;
          reload_cnt[req.timer_index] = req.interval;
        end
      end
      FN_DISARM: begin
        if (req.timer_index < n) remaining_cnt[req.timer_index] = '0;
      end
      FN_TICK: begin
        ticks_seen++;
        for (int unsigned i = 0; i < n; i++) begin
          if (remaining_cnt[i] != '0) begin
            remaining_cnt[i] = remaining_cnt[i] - 1'b1;
            if (remaining_cnt[i] == '0) begin
              hits.push_back(i);
              remaining_cnt[i] = reload_cnt[i];
            end
          end
        end
        foreach (hits[k]) begin
          exp_item.timer = IndexW'(hits[k]);
          exp_item.last = (k == hits.size() - 1);
          expiry_q.push_back(exp_item);
        end
      end
      default: begin
        // Unused operation code: no effect, no result.
      end
    endcase
  endfunction

  // Driver: present queued requests, hold each one until its transfer, and
  // insert random idle bursts between requests.
  always @(posedge clk_i) begin : src_driver
    logic        next_valid;
    timer_req_t  req;
    int unsigned src_gap;
    if (rst_ni) begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        advance_timers(timer_req_t'({s_axis_tdata[67:0], s_axis_tuser}));
        items_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (src_gap != 0) begin
          src_gap--;
        end else if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
          src_gap = $urandom_range(1, 19) - 1;
        end else if (req_q.size() != 0) begin
          req = req_q.pop_front();
          s_axis_tdata <= {4'b0, req.interval, req.timeout, req.timer_index};
          s_axis_tuser <= req.func;
          next_valid = 1'b1;
        end
      end
      s_axis_tvalid <= next_valid;
    end else begin
      src_gap = 0;
    end
  end

  // Monitor: check each result transfer against the oldest expiry, stall at
  // random, and once hold off for a long stretch so the block backs up.
  always @(posedge clk_i) begin : sink_monitor
    expiry_t     want;
    logic        next_ready;
    int unsigned sink_gap;
    int unsigned long_hold;
    if (rst_ni) begin
      next_ready = 1'b1;
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expiry_q.size() == 0) begin
          $display("%0t: unexpected expiry: expected none, actual timer %0d last %0b",
                   $time, m_axis_tdata[3:0], m_axis_tlast);
          mismatches++;
        end else begin
          want = expiry_q.pop_front();
          if (m_axis_tdata[3:0] !== want.timer) begin
            $display("%0t: expired_timer mismatch: expected %0d, actual %0d",
                     $time, want.timer, m_axis_tdata[3:0]);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last mismatch on timer %0d: expected %0b, actual %0b",
                     $time, want.timer, want.last, m_axis_tlast);
            mismatches++;
          end
        end
        if (!pressure_done && results_seen >= PressureAt &&
            req_q.size() >= PressureBacklog) begin
          long_hold = PressureCycles;
          pressure_done = 1'b1;
        end
      end
      if (long_hold != 0) begin
        long_hold--;
        next_ready = 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        next_ready = 1'b0;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        sink_gap = $urandom_range(1, 19) - 1;
        next_ready = 1'b0;
      end
      m_axis_tready <= next_ready;
    end else begin
      sink_gap = 0;
      long_hold = 0;
    end
  end

  // Count cycles without any transfer on any channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // End the run when the block stops moving.
  initial begin : watchdog
    do @(negedge clk_i); while (quiet_cycles < WatchdogLimit);
    $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
    $display("tb: failure");
    $finish;
  end

  task automatic push_req(logic [FuncW-1:0] fn, logic [IndexW-1:0] idx,
                          logic [CountW-1:0] tmo, logic [CountW-1:0] ivl);
    timer_req_t req;
    req.func = fn;
    req.timer_index = idx;
    req.timeout = tmo;
    req.interval = ivl;
    req_q.push_back(req);
    items_queued++;
  endtask

  // Queue random requests: mostly arms with short timeouts and ticks, so that
  // timers expire often, plus disarms, large counts and unused codes.
  task automatic push_random(int unsigned count);
    int unsigned       pick;
    int unsigned       n;
    logic [FuncW-1:0]  fn;
    logic [IndexW-1:0] idx;
    logic [CountW-1:0] tmo;
    logic [CountW-1:0] ivl;
    n = scan_count();
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) fn = FN_ARM;
      else if (pick < 60) fn = FN_DISARM;
      else if (pick < 95) fn = FN_TICK;
      else fn = FnUnused;
      if (n != 0 && $urandom_range(0, 99) < 80) idx = IndexW'($urandom_range(0, n - 1));
      else idx = IndexW'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 10) tmo = '0;
      else if (pick < 75) tmo = $urandom_range(1, 6);
      else if (pick < 80) tmo = '1;
      else tmo = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 40) ivl = '0;
      else if (pick < 85) ivl = $urandom_range(1, 6);
      else if (pick < 90) ivl = '1;
      else ivl = $urandom;
      push_req(fn, idx, tmo, ivl);
    end
  endtask

  // Wait until every request is taken and every expiry has arrived, then
  // let any tick still walking the bank finish.
  task automatic settle();
    do @(negedge clk_i); while (items_accepted != items_queued || expiry_q.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Write the timers-in-use register; call only while the block is idle.
  task automatic write_setting(logic [UseW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    in_use_cfg = value;
    settings_written++;
  endtask

  // Next phase: settle, change the setting, pick idling, queue random traffic.
  task automatic next_phase(logic [UseW-1:0] value, int unsigned count,
                            int unsigned src_pct, int unsigned sink_pct);
    settle();
    write_setting(value);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    push_random(count);
  endtask

  initial begin : sequencer
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part over the full bank.
    write_setting(5'd16);
    src_idle_pct = 8;
    sink_idle_pct = 8;
    push_req(FN_TICK, 4'd0, '0, '0);            // nothing armed: no result
    push_req(FN_ARM, 4'd0, 32'd1, '0);          // one-shot
    push_req(FN_ARM, 4'd15, 32'd1, 32'd2);      // periodic, top index
    push_req(FN_ARM, 4'd7, '0, 32'd5);          // zero timeout stays disarmed
    push_req(FN_ARM, 4'd3, '1, '1);             // largest counts
    push_req(FN_TICK, 4'd0, '0, '0);            // timers 0 and 15 expire
    push_req(FN_TICK, 4'd9, '1, '1);            // tick ignores its other fields
    push_req(FN_TICK, 4'd0, '0, '0);            // timer 15 again
    push_req(FN_ARM, 4'd4, 32'd2, 32'd1);
    push_req(FN_DISARM, 4'd15, '1, '1);         // disarm ignores counts
    push_req(FN_TICK, 4'd0, '0, '0);            // no expiry
    push_req(FN_TICK, 4'd0, '0, '0);            // timer 4
    push_req(FN_TICK, 4'd0, '0, '0);            // timer 4 every tick now
    push_req(FnUnused, 4'd4, '1, '1);           // unused code: ignored
    push_req(FN_DISARM, 4'd0, '0, '0);          // disarm of an expired one-shot
    push_req(FN_TICK, 4'd0, '0, '0);
    push_req(FN_ARM, 4'd12, 32'd1, '0);
    push_req(FN_TICK, 4'd0, '0, '0);            // timers 4 and 12
    push_req(FN_DISARM, 4'd4, '0, '0);
    push_req(FN_TICK, 4'd0, '0, '0);            // no expiry
    push_random(55);

    // Partial bank: indexes at and above the setting are ignored.
    settle();
    write_setting(5'd5);
    src_idle_pct = 0;
    sink_idle_pct = 10;
    push_req(FN_ARM, 4'd5, 32'd1, '0);
    push_req(FN_ARM, 4'd4, 32'd1, '0);
    push_req(FN_TICK, 4'd0, '0, '0);            // timer 4 expires, not timer 5
    push_random(35);

    next_phase(5'd0, 15, 10, 10);               // nothing in use
    next_phase(5'd1, 20, 5, 0);
    next_phase(5'd31, 45, 10, 10);              // above the bank: saturate
    next_phase(5'd20, 15, 5, 5);
    next_phase(5'd12, 55, 0, 0);                // closing stretch, no idling

    settle();
    $display("summary: %0d requests (%0d ticks) under %0d settings, %0d expiries checked",
             items_accepted, ticks_seen, settings_written, results_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("summary: %0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
